// ===== src/bus_frame_transmitter_defines.svh =====
// Assertion macros used by the byte sequencer of the frame transmitter RTL.
`ifndef BUS_FRAME_TRANSMITTER_DEFINES_SVH
`define BUS_FRAME_TRANSMITTER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a condition that must hold at every clock edge outside reset.
`define BFT_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bus_frame_transmitter assertion failed");

// Checks that a consequence holds in the cycle after its trigger.
`define BFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bus_frame_transmitter assertion failed");

`else

`define BFT_ASSERT(lbl, clk, rst_n, expr)
`define BFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/bft_pkg.sv =====
// Types, codes and constants of the frame transmitter.
package bft_pkg;

    // Request codes.
    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_EMPTY = 2'd1;
    localparam logic [1:0] REQ_ACK   = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_START = 2'd0;
    localparam logic [1:0] CFG_DEST_ADDR   = 2'd1;
    localparam logic [1:0] CFG_SRC_ADDR    = 2'd2;
    localparam logic [1:0] CFG_ACK_TYPE    = 2'd3;

    localparam logic [7:0] RST_FRAME_START = 8'd30;
    localparam logic [7:0] RST_DEST_ADDR   = 8'd0;
    localparam logic [7:0] RST_SRC_ADDR    = 8'd12;
    localparam logic [7:0] RST_ACK_TYPE    = 8'd127;

    localparam logic [7:0] SEQ_BASE = 8'h40;
    localparam logic [7:0] PAD_BYTE = 8'h00;
    localparam logic [7:0] ACK_LEN  = 8'd2;
    localparam logic [7:0] HDR_ZERO = 8'h00;

    // Byte slots of a frame, in the order they go out.
    localparam int NUM_STEPS = 12;
    localparam logic [3:0] STEP_START    = 4'd0;
    localparam logic [3:0] STEP_DEST     = 4'd1;
    localparam logic [3:0] STEP_SRC      = 4'd2;
    localparam logic [3:0] STEP_TYPE     = 4'd3;
    localparam logic [3:0] STEP_ZERO     = 4'd4;
    localparam logic [3:0] STEP_LEN      = 4'd5;
    localparam logic [3:0] STEP_BODY1    = 4'd6;
    localparam logic [3:0] STEP_BODY2    = 4'd7;
    localparam logic [3:0] STEP_SEQ      = 4'd8;
    localparam logic [3:0] STEP_PAD      = 4'd9;
    localparam logic [3:0] STEP_CHK_EVEN = 4'd10;
    localparam logic [3:0] STEP_CHK_ODD  = 4'd11;

    localparam int CMD_DEPTH = 4;

    typedef logic [NUM_STEPS-1:0] t_step_mask;

    typedef struct packed {
        logic [7:0] frame_start;
        logic [7:0] dest_address;
        logic [7:0] src_address;
        logic [7:0] ack_frame_type;
    } t_cfg;

    // One command for the back end: which slots to send and their variable bytes.
    typedef struct packed {
        t_step_mask mask;
        logic [7:0] hdr_type;
        logic [7:0] hdr_len;
        logic [7:0] body1;
        logic [7:0] body2;
        logic [2:0] seq;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== src/bft_in_if.sv =====
// Request channel of the frame transmitter.
interface bft_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] msg_type;
    logic [7:0] payload_len;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [3:0] ack_seq;

    modport source (
        output valid, req_type, msg_type, payload_len, data_byte, last_byte, ack_seq,
        input  ready
    );
    modport sink (
        input  valid, req_type, msg_type, payload_len, data_byte, last_byte, ack_seq,
        output ready
    );
endinterface

// ===== src/bft_out_if.sv =====
// Byte stream channel of the frame transmitter.
interface bft_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (
        output valid, out_byte, frame_end,
        input  ready
    );
    modport sink (
        input  valid, out_byte, frame_end,
        output ready
    );
endinterface

// ===== src/bft_cmd_queue.sv =====
// Command queue between the request front end and the byte sequencer.
module bft_cmd_queue
    import bft_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        n_wr    = i_push ? ptr_inc(r_wr) : r_wr;
        n_rd    = i_pop ? ptr_inc(r_rd) : r_rd;
        n_count = r_count + CW'(i_push) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== src/bft_front.sv =====
// Request front end: configuration registers, message tracking and command build.
module bft_front
    import bft_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    bft_in_if.sink      i_req,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_cmd        o_cmd,
    output t_cfg        o_cfg
);
    t_cfg       r_cfg;
    logic [2:0] r_seq, n_seq;
    logic       r_in_msg, n_in_msg;
    logic       r_pad, n_pad;
    logic       accept;
    logic       pad_now;
    t_cmd       cmd;

    assign i_req.ready = !i_q_status.full;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        cmd      = '0;
        n_seq    = r_seq;
        n_in_msg = r_in_msg;
        n_pad    = r_pad;
        pad_now  = r_in_msg ? r_pad : !i_req.payload_len[0];
        unique case (i_req.req_type)
            REQ_DATA: begin
                if (!r_in_msg) begin
                    cmd.mask[STEP_LEN:STEP_START] = '1;
                    cmd.hdr_type = i_req.msg_type;
                    cmd.hdr_len  = i_req.payload_len + 8'd1;
                end
                cmd.mask[STEP_BODY1] = 1'b1;
                cmd.body1            = i_req.data_byte;
                if (i_req.last_byte) begin
                    cmd.mask[STEP_SEQ]      = 1'b1;
                    cmd.mask[STEP_PAD]      = pad_now;
                    cmd.mask[STEP_CHK_ODD:STEP_CHK_EVEN] = '1;
                    cmd.seq  = r_seq;
                    n_seq    = r_seq + 3'd1;
                    n_in_msg = 1'b0;
                    n_pad    = 1'b0;
                end else begin
                    n_in_msg = 1'b1;
                    n_pad    = pad_now;
                end
            end
            REQ_EMPTY: begin
                cmd.mask     = '1;
                cmd.mask[STEP_BODY1] = 1'b0;
                cmd.mask[STEP_BODY2] = 1'b0;
                cmd.hdr_type = i_req.msg_type;
                cmd.hdr_len  = 8'd1;
                cmd.seq      = r_seq;
                n_seq        = r_seq + 3'd1;
                n_in_msg     = 1'b0;
                n_pad        = 1'b0;
            end
            REQ_ACK: begin
                cmd.mask     = '1;
                cmd.mask[STEP_SEQ] = 1'b0;
                cmd.mask[STEP_PAD] = 1'b0;
                cmd.hdr_type = r_cfg.ack_frame_type;
                cmd.hdr_len  = ACK_LEN;
                cmd.body1    = i_req.msg_type;
                cmd.body2    = {4'd0, i_req.ack_seq};
                n_in_msg     = 1'b0;
                n_pad        = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_push = accept && (i_req.req_type != REQ_NONE);
    assign o_cmd  = cmd;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= '0;
            r_in_msg <= 1'b0;
            r_pad    <= 1'b0;
        end else if (accept) begin
            r_seq    <= n_seq;
            r_in_msg <= n_in_msg;
            r_pad    <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_start    <= RST_FRAME_START;
            r_cfg.dest_address   <= RST_DEST_ADDR;
            r_cfg.src_address    <= RST_SRC_ADDR;
            r_cfg.ack_frame_type <= RST_ACK_TYPE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_START: r_cfg.frame_start    <= i_cfg_data;
                CFG_DEST_ADDR:   r_cfg.dest_address   <= i_cfg_data;
                CFG_SRC_ADDR:    r_cfg.src_address    <= i_cfg_data;
                CFG_ACK_TYPE:    r_cfg.ack_frame_type <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/bft_back.sv =====
// Byte sequencer: expands commands into frame bytes and keeps the XOR checksums.
`include "bus_frame_transmitter_defines.svh"

module bft_back
    import bft_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_cmd      i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    bft_out_if.source o_frame
);
    t_cmd       r_cmd;
    t_step_mask r_mask, n_mask, mask_after;
    logic [7:0] r_even, n_even;
    logic [7:0] r_odd, n_odd;
    logic       r_pos, n_pos;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic       slot_free;
    logic       emit;
    logic       pop;
    logic [3:0] sel;
    logic [7:0] cur_byte;

    // Lowest pending slot goes out first.
    function automatic logic [3:0] first_step(input t_step_mask m);
        logic [3:0] idx;
        idx = '0;
        for (int i = NUM_STEPS - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = 4'(i);
            end
        end
        first_step = idx;
    endfunction

    assign slot_free  = !r_out_valid || o_frame.ready;
    assign sel        = first_step(r_mask);
    assign emit       = slot_free && (r_mask != '0);
    assign mask_after = emit ? (r_mask & ~(t_step_mask'(1) << sel)) : r_mask;
    assign pop        = !i_q_status.empty && (mask_after == '0);
    assign n_mask     = pop ? i_head.mask : mask_after;
    assign o_pop      = pop;

    always_comb begin
        unique case (sel)
            STEP_START:    cur_byte = i_cfg.frame_start;
            STEP_DEST:     cur_byte = i_cfg.dest_address;
            STEP_SRC:      cur_byte = i_cfg.src_address;
            STEP_TYPE:     cur_byte = r_cmd.hdr_type;
            STEP_ZERO:     cur_byte = HDR_ZERO;
            STEP_LEN:      cur_byte = r_cmd.hdr_len;
            STEP_BODY1:    cur_byte = r_cmd.body1;
            STEP_BODY2:    cur_byte = r_cmd.body2;
            STEP_SEQ:      cur_byte = SEQ_BASE | {5'd0, r_cmd.seq};
            STEP_PAD:      cur_byte = PAD_BYTE;
            STEP_CHK_EVEN: cur_byte = r_even;
            STEP_CHK_ODD:  cur_byte = r_odd;
            default:       cur_byte = PAD_BYTE;
        endcase
    end

    always_comb begin
        n_even = r_even;
        n_odd  = r_odd;
        n_pos  = r_pos;
        if (emit) begin
            unique case (sel)
                STEP_START: begin
                    n_even = cur_byte;
                    n_odd  = '0;
                    n_pos  = 1'b1;
                end
                STEP_CHK_EVEN: begin
                end
                STEP_CHK_ODD: begin
                    n_even = '0;
                    n_odd  = '0;
                    n_pos  = 1'b0;
                end
                default: begin
                    if (r_pos) begin
                        n_odd = r_odd ^ cur_byte;
                    end else begin
                        n_even = r_even ^ cur_byte;
                    end
                    n_pos = !r_pos;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_even      <= '0;
            r_odd       <= '0;
            r_pos       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            r_even <= n_even;
            r_odd  <= n_odd;
            r_pos  <= n_pos;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_head;
        end
        if (emit) begin
            r_out_byte <= cur_byte;
            r_out_end  <= (sel == STEP_CHK_ODD);
        end
    end

    assign o_frame.valid     = r_out_valid;
    assign o_frame.out_byte  = r_out_byte;
    assign o_frame.frame_end = r_out_end;

    // After the last checksum the accumulators are back at their start values.
    `BFT_ASSERT_NEXT(a_chk_restart, i_clk, i_rst_n, emit && (sel == STEP_CHK_ODD), (r_even == '0) && (r_odd == '0) && !r_pos)
    // The start byte sits at an even position, so the next byte is odd.
    `BFT_ASSERT_NEXT(a_start_parity, i_clk, i_rst_n, emit && (sel == STEP_START), r_pos && (r_odd == '0))
    // A held end-of-frame byte always follows a cleared checksum state.
    `BFT_ASSERT(a_end_clears, i_clk, i_rst_n, !(r_out_valid && r_out_end) || ((r_even == '0) && (r_odd == '0) && !r_pos))
    // A new command is loaded only once the current one has sent every slot.
    `BFT_ASSERT(a_pop_drained, i_clk, i_rst_n, !pop || (mask_after == '0))

endmodule

// ===== src/bus_frame_transmitter.sv =====
// Top level of the serial-link frame transmitter.
//
// Requests arrive on i_req (valid/ready). A data payload byte, an empty data
// message or an acknowledge request is taken per transfer; the front end tracks
// whether a message is open, builds one command per request and places it in a
// short command queue. The back end turns each command into bytes: header, body,
// sequence byte (none for an acknowledge), optional pad and two XOR checksums,
// one byte per cycle on o_frame while the receiver is ready, with frame_end set
// on the final checksum byte. An accepted request passes through the command
// queue and the slot mask before its first byte reaches the output register.
// A payload byte inside an open message adds one output byte, so payload
// streams at one transfer per cycle while the receiver is ready; a request with
// a full header and trailer sends up to 11 bytes.
// The request side keeps accepting until the queue (QUEUE_DEPTH entries, CMD_DEPTH by default) is full.
// Reset clears the sequence counter, the open-message state, the queue and the
// output register, and loads the configuration defaults. When the receiver
// stalls, the output byte holds, and the queue then fills and drops i_req.ready.
// Configuration writes on i_cfg_we take effect at the next edge.
module bus_frame_transmitter
    import bft_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    bft_in_if.sink     i_req,
    bft_out_if.source  o_frame
);
    t_cfg      cfg;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      push;
    logic      pop;
    t_q_status q_status;

    bft_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .o_cfg      (cfg)
    );

    bft_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    bft_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_head     (head_cmd),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_frame    (o_frame)
    );

endmodule

// ===== bench/bft_frame_checker.sv =====
// Checker that predicts the framed byte stream and compares it with the output channel.
module bft_frame_checker
    import bft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    bft_in_if          i_req,
    bft_out_if         i_frame,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
    } t_frame_byte;

    t_frame_byte expected_bytes[$];
    t_cfg        cfg;
    logic [2:0]  seq_num;
    logic [7:0]  even_sum;
    logic [7:0]  odd_sum;
    logic        odd_slot;
    logic        msg_open;
    logic        pad_due;
    int          failures = 0;

    function automatic void clear_sums();
        even_sum = '0;
        odd_sum  = '0;
        odd_slot = 1'b0;
    endfunction

    // A frame byte that counts toward the position checksums.
    function automatic void add_byte(input logic [7:0] b);
        if (odd_slot) begin
            odd_sum ^= b;
        end else begin
            even_sum ^= b;
        end
        odd_slot = ~odd_slot;
        expected_bytes.push_back('{data: b, frame_end: 1'b0});
    endfunction

    function automatic void add_header(input logic [7:0] hdr_type, input logic [7:0] hdr_len);
        clear_sums();
        add_byte(cfg.frame_start);
        add_byte(cfg.dest_address);
        add_byte(cfg.src_address);
        add_byte(hdr_type);
        add_byte(HDR_ZERO);
        add_byte(hdr_len);
    endfunction

    function automatic void add_checksums();
        expected_bytes.push_back('{data: even_sum, frame_end: 1'b0});
        expected_bytes.push_back('{data: odd_sum, frame_end: 1'b1});
        clear_sums();
    endfunction

    function automatic void close_message();
        add_byte(SEQ_BASE + {5'b0, seq_num});
        seq_num = seq_num + 3'd1;
        if (pad_due) begin
            add_byte(PAD_BYTE);
        end
        add_checksums();
        msg_open = 1'b0;
        pad_due  = 1'b0;
    endfunction

    function automatic void predict_request(
        input logic [1:0] kind,
        input logic [7:0] mtype,
        input logic [7:0] plen,
        input logic [7:0] dbyte,
        input logic       fin,
        input logic [3:0] aseq
    );
        case (kind)
            REQ_DATA: begin
                if (!msg_open) begin
                    add_header(mtype, plen + 8'd1);
                    // The pad keeps the frame length even.
                    pad_due  = ~plen[0];
                    msg_open = 1'b1;
                end
                add_byte(dbyte);
                if (fin) begin
                    close_message();
                end
            end
            REQ_EMPTY: begin
                msg_open = 1'b0;
                add_header(mtype, 8'd1);
                pad_due = 1'b1;
                close_message();
            end
            REQ_ACK: begin
                msg_open = 1'b0;
                pad_due  = 1'b0;
                add_header(cfg.ack_frame_type, ACK_LEN);
                add_byte(mtype);
                add_byte({4'b0, aseq});
                add_checksums();
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_frame_byte want;
        if (!i_rst_n) begin
            cfg = '{RST_FRAME_START, RST_DEST_ADDR, RST_SRC_ADDR, RST_ACK_TYPE};
            seq_num  = '0;
            msg_open = 1'b0;
            pad_due  = 1'b0;
            clear_sums();
            expected_bytes.delete();
        end else begin
            // Output is checked before the request of the same edge is predicted.
            if (i_frame.valid && i_frame.ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte %02h, frame_end %b", $time,
                             i_frame.out_byte, i_frame.frame_end);
                    failures++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_frame.out_byte !== want.data) begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h", $time,
                                 want.data, i_frame.out_byte);
                        failures++;
                    end
                    if (i_frame.frame_end !== want.frame_end) begin
                        $display("%0t: frame_end mismatch, expected %b, actual %b", $time,
                                 want.frame_end, i_frame.frame_end);
                        failures++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FRAME_START: cfg.frame_start    = i_cfg_data;
                    CFG_DEST_ADDR:   cfg.dest_address   = i_cfg_data;
                    CFG_SRC_ADDR:    cfg.src_address    = i_cfg_data;
                    CFG_ACK_TYPE:    cfg.ack_frame_type = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_req.valid && i_req.ready) begin
                predict_request(i_req.req_type, i_req.msg_type, i_req.payload_len,
                                i_req.data_byte, i_req.last_byte, i_req.ack_seq);
            end
        end
        o_fail_count <= failures;
        o_pending    <= expected_bytes.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Top of the frame transmitter testbench: clock, reset, stimulus and verdict.
module tb_top
    import bft_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_PHASE = 80;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_idx;
    logic [7:0] cfg_data;
    int         fail_count;
    int         pending;
    int         idle_cycles  = 0;
    int         items_sent   = 0;
    int         tx_idle_pct  = 0;
    int         rx_stall_pct = 0;

    bft_in_if  req_ch ();
    bft_out_if frame_ch ();

    always #4 clk = ~clk;

    bus_frame_transmitter uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_frame    (frame_ch)
    );

    bft_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_req        (req_ch),
        .i_frame      (frame_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        frame_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (frame_ch.valid && frame_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    // Holds the request side low until every predicted byte has been taken.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_req(
        input logic [1:0] kind,
        input logic [7:0] mtype,
        input logic [7:0] plen,
        input logic [7:0] dbyte,
        input logic       fin,
        input logic [3:0] aseq
    );
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.msg_type    <= mtype;
        req_ch.payload_len <= plen;
        req_ch.data_byte   <= dbyte;
        req_ch.last_byte   <= fin;
        req_ch.ack_seq     <= aseq;
        do @(posedge clk); while (!req_ch.ready);
        if (kind != REQ_NONE) begin
            items_sent++;
        end
        if ($urandom_range(99) < 3) begin
            wait_drained();
        end
    endtask

    task automatic send_noise();
        send_req(REQ_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 1'($urandom_range(1)), 4'($urandom_range(15)));
    endtask

    // A data message; an abandoned one stops without its closing byte.
    task automatic send_message(input bit abandon);
        logic [7:0] plen;
        int         nbytes;
        plen = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1, 6));
        nbytes = ($urandom_range(4) == 0 || plen > 8'd6) ? $urandom_range(1, 6) : int'(plen);
        for (int k = 1; k <= nbytes; k++) begin
            if ($urandom_range(19) == 0) begin
                send_noise();
            end
            send_req(REQ_DATA, 8'($urandom_range(255)),
                     (k == 1) ? plen : 8'($urandom_range(255)), 8'($urandom_range(255)),
                     (k == nbytes) && !abandon, 4'($urandom_range(15)));
        end
    endtask

    task automatic random_action();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            send_message(1'b0);
        end else if (pick < 70) begin
            send_message(1'b1);
        end else if (pick < 82) begin
            send_req(REQ_EMPTY, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 1'($urandom_range(1)), 4'($urandom_range(15)));
        end else if (pick < 95) begin
            send_req(REQ_ACK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 1'($urandom_range(1)), 4'($urandom_range(15)));
        end else begin
            send_noise();
        end
    endtask

    task automatic write_config(
        input logic [7:0] start,
        input logic [7:0] dest,
        input logic [7:0] src,
        input logic [7:0] ack
    );
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FRAME_START;
        cfg_data <= start;
        @(posedge clk);
        cfg_idx  <= CFG_DEST_ADDR;
        cfg_data <= dest;
        @(posedge clk);
        cfg_idx  <= CFG_SRC_ADDR;
        cfg_data <= src;
        @(posedge clk);
        cfg_idx  <= CFG_ACK_TYPE;
        cfg_data <= ack;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_FRAME_START;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_NONE;
        req_ch.msg_type    <= '0;
        req_ch.payload_len <= '0;
        req_ch.data_byte   <= '0;
        req_ch.last_byte   <= 1'b0;
        req_ch.ack_seq     <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset defaults of the registers.
        send_req(REQ_EMPTY, 8'h00, 8'h00, 8'h00, 1'b0, 4'h0);
        send_req(REQ_EMPTY, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'hF);
        send_req(REQ_ACK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'hF);
        send_req(REQ_ACK, 8'h00, 8'h00, 8'h00, 1'b0, 4'h0);
        send_req(REQ_DATA, 8'h12, 8'd0, 8'h00, 1'b1, 4'h0);
        send_req(REQ_DATA, 8'h34, 8'd1, 8'hFF, 1'b1, 4'h0);
        // A declared length of 255 wraps the length byte to zero.
        send_req(REQ_DATA, 8'h56, 8'd255, 8'hA5, 1'b1, 4'h0);
        // Fewer bytes than declared; later bytes carry fields that must be ignored.
        send_req(REQ_DATA, 8'h78, 8'd254, 8'h5A, 1'b0, 4'h0);
        send_req(REQ_DATA, 8'h11, 8'd3, 8'hFF, 1'b0, 4'h0);
        send_req(REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'hF);
        send_req(REQ_DATA, 8'h22, 8'd7, 8'h01, 1'b1, 4'h0);
        send_req(REQ_NONE, 8'h00, 8'h00, 8'h00, 1'b0, 4'h0);
        // An open message is dropped by an empty message, then by an acknowledge.
        send_req(REQ_DATA, 8'h9A, 8'd2, 8'hC3, 1'b0, 4'h0);
        send_req(REQ_EMPTY, 8'hBC, 8'd0, 8'h00, 1'b0, 4'h0);
        send_req(REQ_DATA, 8'hDE, 8'd3, 8'h3C, 1'b0, 4'h0);
        send_req(REQ_ACK, 8'h81, 8'd0, 8'h00, 1'b0, 4'h9);
        send_req(REQ_DATA, 8'h42, 8'd3, 8'h10, 1'b0, 4'h0);
        send_req(REQ_DATA, 8'h42, 8'd3, 8'h20, 1'b0, 4'h0);
        send_req(REQ_DATA, 8'h42, 8'd3, 8'h30, 1'b1, 4'h0);

        for (int phase = 0; phase < 3; phase++) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (phase)
                0: begin
                    write_config(8'h00, 8'h00, 8'h00, 8'h00);
                    tx_idle_pct  = 28;
                    rx_stall_pct <= 59;
                end
                1: begin
                    write_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
                    tx_idle_pct  = 59;
                    rx_stall_pct <= 28;
                end
                default: begin
                    write_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)));
                    tx_idle_pct  = 0;
                    rx_stall_pct <= 0;
                end
            endcase
            while (items_sent < 19 + (phase + 1) * ITEMS_PER_PHASE) begin
                random_action();
            end
            // Close whatever message is still open so the next register write sees no frame.
            send_req(REQ_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)), 1'b1, 4'($urandom_range(15)));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
